FILE: rtl/core/csps_pkg.sv
// Shared types and constants for the convex support point search block.
// No dependencies; imported by csps_dot_unit and the top level.
package csps_pkg;

    localparam int FIELD_INDEX_W = 8;
    localparam int FIELD_COORD_W = 16;
    localparam int CFG_W         = 9;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 8;

    localparam int OFS_INDEX = 0;
    localparam int OFS_X     = 8;
    localparam int OFS_Y     = 24;
    localparam int OFS_Z     = 40;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control that travels with one memory read into the dot product unit.
    typedef struct packed {
        logic start;
        logic vld;
        logic base;
    } dot_ctl_t;

endpackage

FILE: rtl/core/csps_vertex_mem.sv
// Vertex store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module csps_vertex_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/csps_dot_unit.sv
// Shared projection unit: difference, three products, sum, and running maximum.
// Depends on csps_pkg for the control struct.
module csps_dot_unit
    import csps_pkg::*;
#(
    parameter int EFF_W = 16,
    parameter int IDX_W = 8,
    parameter int BI_W  = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dot_ctl_t                ctl,
    input  logic [IDX_W-1:0]        idx,
    input  logic [3*EFF_W-1:0]      vtx,
    input  logic signed [EFF_W-1:0] axis_x,
    input  logic signed [EFF_W-1:0] axis_y,
    input  logic signed [EFF_W-1:0] axis_z,
    output logic                    busy,
    output logic [BI_W-1:0]         best_idx
);

    localparam int DIF_W = EFF_W + 1;
    localparam int PRD_W = 2 * EFF_W + 1;
    localparam int SUM_W = 2 * EFF_W + 3;

    logic signed [EFF_W-1:0] vx;
    logic signed [EFF_W-1:0] vy;
    logic signed [EFF_W-1:0] vz;

    logic signed [EFF_W-1:0] base_x_reg;
    logic signed [EFF_W-1:0] base_y_reg;
    logic signed [EFF_W-1:0] base_z_reg;

    logic                    s1_vld_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic signed [DIF_W-1:0] dx_reg;
    logic signed [DIF_W-1:0] dy_reg;
    logic signed [DIF_W-1:0] dz_reg;

    logic                    s2_vld_reg;
    logic [IDX_W-1:0]        s2_idx_reg;
    logic signed [PRD_W-1:0] px_reg;
    logic signed [PRD_W-1:0] py_reg;
    logic signed [PRD_W-1:0] pz_reg;

    logic                    s3_vld_reg;
    logic [IDX_W-1:0]        s3_idx_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic signed [SUM_W-1:0] best_proj_reg;
    logic [BI_W-1:0]         best_idx_reg;

    assign vx = vtx[0*EFF_W +: EFF_W];
    assign vy = vtx[1*EFF_W +: EFF_W];
    assign vz = vtx[2*EFF_W +: EFF_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctl.vld && !ctl.base;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld && ctl.base)
        begin
            base_x_reg <= vx;
            base_y_reg <= vy;
            base_z_reg <= vz;
        end
        s1_idx_reg <= idx;
        dx_reg     <= DIF_W'(vx) - DIF_W'(base_x_reg);
        dy_reg     <= DIF_W'(vy) - DIF_W'(base_y_reg);
        dz_reg     <= DIF_W'(vz) - DIF_W'(base_z_reg);

        s2_idx_reg <= s1_idx_reg;
        px_reg     <= PRD_W'(axis_x) * PRD_W'(dx_reg);
        py_reg     <= PRD_W'(axis_y) * PRD_W'(dy_reg);
        pz_reg     <= PRD_W'(axis_z) * PRD_W'(dz_reg);

        s3_idx_reg <= s2_idx_reg;
        sum_reg    <= SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg);

        if (ctl.start)
        begin
            best_proj_reg <= '0;
            best_idx_reg  <= '0;
        end
        else if (s3_vld_reg && (sum_reg > best_proj_reg))
        begin
            best_proj_reg <= sum_reg;
            best_idx_reg  <= BI_W'(s3_idx_reg);
        end
    end

    assign busy     = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign best_idx = best_idx_reg;

endmodule

FILE: rtl/core/convex_support_point_search_top.sv
// Top level of the convex support point search block: ports, sequencer, store.
// Depends on csps_pkg, csps_vertex_mem and csps_dot_unit.
//
//  channel  direction  signals                          transaction
//  s        in         s_tvalid s_tready s_tdata s_tuser write vertex or query axis
//  m        out        m_tvalid m_tready m_tdata        support index of one query
//  cfg      in         cfg_valid cfg_ready cfg_data     vertex_count register
//
//  In a query the sequencer reads one vertex per cycle from the single store read port
//  through a four-stage difference, multiply, sum and compare pipeline, then drains it.
//  rst_n clears control state and sets vertex_count to 1; the store is not cleared.
//  The input stays stalled while a query runs; a finished query holds in ST_DONE
//  while the previous result still waits on m_tready.
module convex_support_point_search_top
    import csps_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // vertex_index, coord_x, coord_y, coord_z
    input  logic                 s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // support_index
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data   // vertex_count
);

    localparam int EFF_W = (COORD_WIDTH < 8) ? 8 : ((COORD_WIDTH > 16) ? 16 : COORD_WIDTH);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int BI_W  = (IDX_W > M_TDATA_W) ? IDX_W : M_TDATA_W;
    localparam int VTX_W = 3 * EFF_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        count_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic signed [EFF_W-1:0] ax_reg;
    logic signed [EFF_W-1:0] ay_reg;
    logic signed [EFF_W-1:0] az_reg;
    dot_ctl_t                dctl_reg;
    logic [IDX_W-1:0]        didx_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    s_accept;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [VTX_W-1:0]        wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [VTX_W-1:0]        rd_data;
    logic [CNT_W-1:0]        n_eff;
    dot_ctl_t                ctl_next;
    logic                    dot_busy;
    logic [BI_W-1:0]         best_idx;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    assign wr_en   = s_accept && (s_tuser == OP_WRITE)
                     && (32'(s_tdata[OFS_INDEX +: FIELD_INDEX_W]) < MAX_VERTICES);
    assign wr_addr = IDX_W'(s_tdata[OFS_INDEX +: FIELD_INDEX_W]);
    assign wr_data = {s_tdata[OFS_Z +: EFF_W], s_tdata[OFS_Y +: EFF_W], s_tdata[OFS_X +: EFF_W]};

    always_comb
    begin
        priority if (count_reg == '0)
            n_eff = CNT_W'(1);
        else if (32'(count_reg) > MAX_VERTICES)
            n_eff = CNT_W'(MAX_VERTICES);
        else
            n_eff = CNT_W'(count_reg);
    end

    always_comb
    begin
        ctl_next = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && (s_tuser == OP_QUERY))
                begin
                    ctl_next.start = 1'b1;
                    ctl_next.vld   = 1'b1;
                    ctl_next.base  = 1'b1;
                    rd_en          = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < n_reg)
                begin
                    ctl_next.vld = 1'b1;
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[IDX_W-1:0];
                end
            end
            ST_DRAIN, ST_DONE:
            begin
                ctl_next = '0;
            end
            default:
            begin
                ctl_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dctl_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            dctl_reg <= ctl_next;
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept && (s_tuser == OP_QUERY))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg >= n_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!dot_busy && !dctl_reg.vld)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg <= rd_addr;
        if (s_accept)
        begin
            ax_reg  <= s_tdata[OFS_X +: EFF_W];
            ay_reg  <= s_tdata[OFS_Y +: EFF_W];
            az_reg  <= s_tdata[OFS_Z +: EFF_W];
            n_reg   <= n_eff;
            idx_reg <= CNT_W'(1);
        end
        else if (rd_en)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= best_idx[M_TDATA_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    csps_vertex_mem #(
        .DEPTH  (MAX_VERTICES),
        .WIDTH  (VTX_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csps_dot_unit #(
        .EFF_W (EFF_W),
        .IDX_W (IDX_W),
        .BI_W  (BI_W)
    ) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl_reg),
        .idx      (didx_reg),
        .vtx      (rd_data),
        .axis_x   (ax_reg),
        .axis_y   (ay_reg),
        .axis_z   (az_reg),
        .busy     (dot_busy),
        .best_idx (best_idx)
    );

endmodule
